>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the pilot decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`endif

>>> rtl/pdfc_pkg.sv
// Package with types, constants and the current lookup of the pilot decoder.
`timescale 1ns / 1ps

package pdfc_pkg;

    localparam int TICK_W   = 16;
    localparam int TOTAL_W  = TICK_W + 1;
    localparam int DEN_W    = TOTAL_W + 1;
    localparam int RATE_W   = 24;
    localparam int REMD_W   = 24;
    localparam int REMF_W   = 26;
    localparam int CMP_W    = 34;
    localparam int DUTY_W   = 7;
    localparam int FREQ_W   = 16;
    localparam int AMPS_W   = 7;

    // Stage 0 forms the operands, one quotient bit per stage after it,
    // then a result stage.
    localparam int DIV_STAGES = FREQ_W;
    localparam int NUM_STAGES = DIV_STAGES + 2;

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd2000000;
    localparam logic [FREQ_W-1:0] FREQ_MAX        = 16'hFFFF;
    localparam logic [REMD_W-1:0] DUTY_SCALE      = 24'd200;

    localparam logic [DUTY_W-1:0] DUTY_MIN      = 7'd8;
    localparam logic [DUTY_W-1:0] DUTY_LOW_END  = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MID_END  = 7'd85;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd96;
    localparam logic [DUTY_W-1:0] DUTY_OFFSET   = 7'd64;
    localparam logic [AMPS_W-1:0] AMPS_LOW      = 7'd6;

    typedef struct packed {
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              measurement_invalid;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_percent;
        logic [FREQ_W-1:0] frequency_hz;
        logic [AMPS_W-1:0] current_amps;
    } t_out_item;

    typedef struct packed {
        logic              zero;
        logic              sat;
        logic [DEN_W-1:0]  den;
        logic [REMD_W-1:0] rem_d;
        logic [REMF_W-1:0] rem_f;
        logic [DUTY_W-1:0] q_d;
        logic [FREQ_W-1:0] q_f;
    } t_stage;

    // Piecewise pilot current. The divide by ten is a multiply by 205 and
    // a shift by 11, exact for the values below 1029 that occur here.
    function automatic logic [AMPS_W-1:0] current_from_duty(input logic [DUTY_W-1:0] duty);
        logic [9:0]        x;
        logic [19:0]       p;
        logic [7:0]        y;
        logic [AMPS_W-1:0] a;
        x = '0;
        p = '0;
        y = '0;
        if (duty < DUTY_MIN || duty > DUTY_MAX) begin
            a = '0;
        end else if (duty < DUTY_LOW_END) begin
            a = AMPS_LOW;
        end else if (duty < DUTY_MID_END) begin
            x = {3'b000, duty} * 10'd6 + 10'd5;
            p = {10'b0, x} * 20'd205;
            a = p[17:11];
        end else begin
            y = {1'b0, duty - DUTY_OFFSET} * 8'd5 + 8'd1;
            a = y[7:1];
        end
        return a;
    endfunction

endpackage

>>> rtl/pwm_pilot_duty_frequency_current.sv
// Pilot PWM decoder: duty percent, frequency and allowed current per period.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each item is one measured PWM period (on and off tick counts plus an
// invalid flag) and gives one result: the off-phase duty rounded to whole
// percent, the frequency rounded to hertz and saturated at 65535, and the
// allowed pilot current in amps. The block takes one item per cycle while
// a stage is free or the output is taken. The frequency divider is a
// restoring divider that resolves one quotient bit per pipeline stage
// over 16 stages, with the 7-bit duty division running in the first seven
// of them. A stall at the output only holds the stages that are full, so
// empty stages still fill. The tick rate register is written through its
// own channel, which is always ready.
module pwm_pilot_duty_frequency_current (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pdfc_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pdfc_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pdfc_pkg::RATE_W-1:0]    i_cfg_data
);

    logic [pdfc_pkg::RATE_W-1:0]         r_tick_rate;
    logic [pdfc_pkg::NUM_STAGES-1:0]     r_v;
    logic [pdfc_pkg::NUM_STAGES-1:0]     en;
    pdfc_pkg::t_stage                    r_st [0:pdfc_pkg::DIV_STAGES];
    pdfc_pkg::t_stage                    n_st [0:pdfc_pkg::DIV_STAGES];
    pdfc_pkg::t_stage                    n_op;
    pdfc_pkg::t_out_item                 r_out;
    pdfc_pkg::t_out_item                 n_out;
    logic [pdfc_pkg::TOTAL_W-1:0]        total;

    // A stage moves when some stage at or after it is empty, or the output
    // is being taken.
    always_comb begin
        for (int k = 0; k < pdfc_pkg::NUM_STAGES; k++) begin
            en[k] = i_out_ready || (((~r_v) >> k) != '0);
        end
    end

    assign o_in_ready  = en[0];
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_v[pdfc_pkg::NUM_STAGES-1];
    assign o_out_item  = r_out;

    // Operand setup. Halves round upward, so both numerators carry an extra
    // total and both divisors are twice the period.
    always_comb begin
        total = {1'b0, i_in_item.high_ticks} + {1'b0, i_in_item.low_ticks};
        n_op.zero  = i_in_item.measurement_invalid || (total == '0);
        n_op.sat   = 1'b0;
        n_op.den   = {total, 1'b0};
        n_op.rem_d = {8'b0, i_in_item.low_ticks} * pdfc_pkg::DUTY_SCALE
                   + {7'b0, total};
        n_op.rem_f = {1'b0, r_tick_rate, 1'b0} + {9'b0, total};
        n_op.q_d   = '0;
        n_op.q_f   = '0;
    end

    // Divider stages: stage k decides frequency bit 16-k, and duty bit 7-k
    // in the first seven stages. The first stage also flags saturation.
    always_comb begin
        logic [pdfc_pkg::CMP_W-1:0] sh_f;
        logic [pdfc_pkg::CMP_W-1:0] sh_d;
        n_st[0] = n_op;
        sh_d    = '0;
        for (int k = 1; k <= pdfc_pkg::DIV_STAGES; k++) begin
            n_st[k] = r_st[k-1];
            sh_f = pdfc_pkg::CMP_W'(r_st[k-1].den) << (pdfc_pkg::FREQ_W - k);
            if (k == 1) begin
                n_st[k].sat = pdfc_pkg::CMP_W'(r_st[k-1].rem_f)
                            >= (pdfc_pkg::CMP_W'(r_st[k-1].den) << pdfc_pkg::FREQ_W);
            end
            if (pdfc_pkg::CMP_W'(r_st[k-1].rem_f) >= sh_f) begin
                n_st[k].rem_f = r_st[k-1].rem_f - sh_f[pdfc_pkg::REMF_W-1:0];
                n_st[k].q_f[pdfc_pkg::FREQ_W-k] = 1'b1;
            end
            if (k <= pdfc_pkg::DUTY_W) begin
                sh_d = pdfc_pkg::CMP_W'(r_st[k-1].den) << (pdfc_pkg::DUTY_W - k);
                if (pdfc_pkg::CMP_W'(r_st[k-1].rem_d) >= sh_d) begin
                    n_st[k].rem_d = r_st[k-1].rem_d - sh_d[pdfc_pkg::REMD_W-1:0];
                    n_st[k].q_d[pdfc_pkg::DUTY_W-k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_st[pdfc_pkg::DIV_STAGES].zero) begin
            n_out = '0;
        end else begin
            n_out.duty_percent = r_st[pdfc_pkg::DIV_STAGES].q_d;
            n_out.frequency_hz = r_st[pdfc_pkg::DIV_STAGES].sat ? pdfc_pkg::FREQ_MAX
                               : r_st[pdfc_pkg::DIV_STAGES].q_f;
            n_out.current_amps =
                pdfc_pkg::current_from_duty(r_st[pdfc_pkg::DIV_STAGES].q_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= pdfc_pkg::TICK_RATE_RESET;
            r_v         <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tick_rate <= i_cfg_data;
            end
            if (en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < pdfc_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= pdfc_pkg::DIV_STAGES; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (en[pdfc_pkg::NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    // Intake only stops when every stage holds an item and the output waits.
    `ASSERT_IMPL(a_stall_from_output, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready && (&r_v))
    `ASSERT_NEVER(a_duty_range, i_clk, i_rst_n, o_out_valid && (o_out_item.duty_percent > 7'd100))
    `ASSERT_IMPL(a_current_needs_duty, i_clk, i_rst_n, o_out_valid && (o_out_item.current_amps != '0), (o_out_item.duty_percent >= pdfc_pkg::DUTY_MIN) && (o_out_item.duty_percent <= pdfc_pkg::DUTY_MAX))

endmodule

>>> tb/sv/tb_pwm_pilot_duty_frequency_current.sv
// Testbench for the pilot PWM decoder: predicts duty, frequency and current per item.
`timescale 1ns / 1ps

module tb_pwm_pilot_duty_frequency_current;
    import pdfc_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int LIMIT      = 400000;
    localparam int LONG_HOLD  = 400;
    localparam int MAX_REPORT = 10;

    // Holds the expected results of accepted measurements and checks them in order.
    class pilot_result_scoreboard;
        t_out_item         expected_results[$];
        logic [RATE_W-1:0] tick_rate;
        int                mismatch_count;
        int                measurements_seen;
        int                results_checked;

        function new();
            tick_rate         = TICK_RATE_RESET;
            mismatch_count    = 0;
            measurements_seen = 0;
            results_checked   = 0;
        endfunction

        function t_out_item decode_period(t_in_item meas);
            t_out_item       r;
            longint unsigned total;
            longint unsigned duty;
            longint unsigned freq;
            longint unsigned amps;
            r     = '0;
            total = meas.high_ticks + meas.low_ticks;
            duty  = 0;
            freq  = 0;
            amps  = 0;
            if (!meas.measurement_invalid && total != 0) begin
                // Round to nearest with halves upward: (2n + d) / 2d.
                duty = (200 * meas.low_ticks + total) / (2 * total);
                freq = (2 * tick_rate + total) / (2 * total);
                if (freq > 65535) begin
                    freq = 65535;
                end
                if (duty < 8 || duty > 96) begin
                    amps = 0;
                end else if (duty < 10) begin
                    amps = 6;
                end else if (duty < 85) begin
                    amps = (6 * duty + 5) / 10;
                end else begin
                    amps = (5 * (duty - 64) + 1) / 2;
                end
            end
            r.duty_percent = DUTY_W'(duty);
            r.frequency_hz = FREQ_W'(freq);
            r.current_amps = AMPS_W'(amps);
            return r;
        endfunction

        function void note_measurement(t_in_item meas);
            expected_results.push_back(decode_period(meas));
            measurements_seen++;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT) begin
                    $display("ERROR: result with no pending item: duty %0d freq %0d amps %0d",
                             got.duty_percent, got.frequency_hz, got.current_amps);
                end
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.duty_percent !== want.duty_percent ||
                got.frequency_hz !== want.frequency_hz ||
                got.current_amps !== want.current_amps) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT) begin
                    $display("ERROR: result %0d: duty exp %0d act %0d, freq exp %0d act %0d, %s%0d act %0d",
                             results_checked, want.duty_percent, got.duty_percent,
                             want.frequency_hz, got.frequency_hz, "amps exp ",
                             want.current_amps, got.current_amps);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [RATE_W-1:0]   i_cfg_data;

    pilot_result_scoreboard sb;
    logic                   hold_req;
    int                     cycle_count;
    int                     rate_settings;

    pwm_pilot_duty_frequency_current dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    // Handshakes are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.tick_rate = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_measurement(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_item);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run did not finish within %0d cycles", LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall patterns, plus one long hold-off on request.
    initial begin
        int seg_left;
        int mode;
        int tick;
        seg_left    = 0;
        mode        = 0;
        tick        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                tick++;
                case (mode)
                    0: begin
                        i_out_ready = 1'b1;
                    end
                    1: begin
                        i_out_ready = 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_out_ready = ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        i_out_ready = (tick % 4 != 0);
                    end
                endcase
            end
        end
    end

    task automatic send_item(input t_in_item meas, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = meas;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_measurement(input int high, input int low, input bit invalid);
        t_in_item meas;
        meas.high_ticks          = TICK_W'(high);
        meas.low_ticks           = TICK_W'(low);
        meas.measurement_invalid = invalid;
        send_item(meas, $urandom_range(0, 2));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
        wait_for_drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        rate_settings++;
    endtask

    function automatic t_in_item random_period();
        t_in_item    meas;
        int          kind;
        int unsigned total;
        int unsigned low;
        meas = '0;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                meas.high_ticks          = TICK_W'($urandom_range(0, 65535));
                meas.low_ticks           = TICK_W'($urandom_range(0, 65535));
                meas.measurement_invalid = 1'($urandom_range(0, 1));
            end
            1: begin
                meas.high_ticks = TICK_W'($urandom_range(0, 3));
                meas.low_ticks  = TICK_W'($urandom_range(0, 3));
            end
            8: begin
                meas.high_ticks          = TICK_W'($urandom_range(0, 65535));
                meas.low_ticks           = TICK_W'($urandom_range(0, 65535));
                meas.measurement_invalid = 1'b1;
            end
            9: begin
                meas.high_ticks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                meas.low_ticks  = $urandom_range(0, 1) ? 16'hFFFF
                                : TICK_W'($urandom_range(0, 1));
            end
            default: begin
                // A plausible period with a chosen duty, sized over all magnitudes.
                total = $urandom_range(1, (1 << $urandom_range(1, 16)) - 1);
                low   = (total * $urandom_range(0, 100)) / 100;
                if ($urandom_range(0, 1) && low < total) begin
                    low = low + 1;
                end
                meas.low_ticks  = TICK_W'(low);
                meas.high_ticks = TICK_W'(total - low);
            end
        endcase
        return meas;
    endfunction

    task automatic run_phase(input int count, input int gap_max);
        int burst_left;
        int gap;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, gap_max);
            end else begin
                gap = 0;
            end
            burst_left--;
            send_item(random_period(), gap);
        end
    endtask

    initial begin
        logic [RATE_W-1:0] rate;
        sb            = new();
        hold_req      = 1'b0;
        rate_settings = 1;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items at the reset tick rate.
        send_measurement(1000, 1000, 1'b0);
        send_measurement(1000, 1000, 1'b1);
        send_measurement(0, 0, 1'b0);
        send_measurement(0, 0, 1'b1);
        send_measurement(65535, 65535, 1'b0);
        send_measurement(65535, 65535, 1'b1);
        send_measurement(65535, 0, 1'b0);
        send_measurement(0, 65535, 1'b0);
        send_measurement(1, 0, 1'b0);
        send_measurement(0, 1, 1'b0);
        // A period of 30 ticks is just fast enough to saturate, 31 is not.
        send_measurement(15, 15, 1'b0);
        send_measurement(16, 15, 1'b0);
        // Duty steps across every edge of the current rule.
        send_measurement(93, 7, 1'b0);
        send_measurement(92, 8, 1'b0);
        send_measurement(91, 9, 1'b0);
        send_measurement(90, 10, 1'b0);
        send_measurement(16, 84, 1'b0);
        send_measurement(15, 85, 1'b0);
        send_measurement(4, 96, 1'b0);
        send_measurement(3, 97, 1'b0);
        // Half-percent duties round upward, both of them onto a rule edge.
        send_measurement(185, 15, 1'b0);
        send_measurement(31, 169, 1'b0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: rate = 24'hFFFFFF;
                1: rate = 24'd1;
                2: rate = '0;
                3: rate = RATE_W'($urandom_range(1, 24'hFFFFFF));
                default: rate = TICK_RATE_RESET;
            endcase
            write_tick_rate(rate);
            if (p == 1) begin
                run_phase(50, 4);
                wait_for_drain();
                run_phase(50, 4);
            end else if (p == 3) begin
                // The output holds off while the input keeps pushing items.
                hold_req = 1'b1;
                run_phase(60, 0);
                run_phase(40, 8);
            end else begin
                run_phase(100, (p == 0) ? 0 : 6);
            end
        end

        wait_for_drain();
        repeat (40) @(negedge i_clk);

        $display("Summary: %0d items decoded and %0d results checked over %0d tick rates,",
                 sb.measurements_seen, sb.results_checked, rate_settings);
        $display("with bursty input, output stalls, a %0d-cycle hold-off and a drain pause.",
                 LONG_HOLD);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
